[src/hlfr_pkg.sv]
// Shared types and constants for the header/length frame receiver.
package hlfr_pkg;

	// Frame position counter: the longest frame is 255 + 3 bytes.
	localparam int POS_W = 9;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [POS_W:0]   pos_cmp_t;

	// Frame layout.
	localparam int FIRST_STORED = 2;   // length byte, first byte kept
	localparam int STORE_BYTES  = 7;   // bytes 2..8 reach the result
	localparam int LEN_BIAS     = 3;   // header and length byte
	localparam logic [7:0] PAYLOAD_LEN = 8'd6;

	// Header defaults.
	localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_BYTE    = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} q_entry_t;

	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
	} sync_t;

	typedef struct packed {
		logic [7:0]  frame_length;
		logic [7:0]  command_type;
		logic [23:0] node_id;
		logic [15:0] payload;
		logic        payload_present;
	} frame_res_t;

endpackage

[src/hlfr_front.sv]
// Input side: decode each word into an operation and queue it for the back end.
module hlfr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [7:0]        rx_byte,
	output logic              q_valid,
	input  logic              q_pop,
	output hlfr_pkg::q_entry_t q_head
);
	import hlfr_pkg::*;

	q_entry_t          ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	q_entry_t          entry;
	logic              push;

	// Classify the word.
	always_comb begin
		entry.op   = req_type ? OP_RELEASE : OP_BYTE;
		entry.data = rx_byte;
	end

	assign in_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign q_head   = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= entry;
		end
	end

endmodule

[src/hlfr_back.sv]
// Frame engine: header hunt, byte collection, completion and result register.
module hlfr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hlfr_pkg::sync_t      sync,
	input  logic                 q_valid,
	input  hlfr_pkg::q_entry_t   q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hlfr_pkg::frame_res_t res
);
	import hlfr_pkg::*;

	pos_t       pos_q, pos_d;
	logic       pending_q, pending_d;
	logic [7:0] store_q [STORE_BYTES];
	logic [7:0] store_d [STORE_BYTES];
	logic       out_valid_q;
	frame_res_t res_q, res_d;
	logic       emit;
	logic       clr;
	logic       take;

	assign take  = !out_valid_q || out_ready;
	assign q_pop = q_valid && take;

	always_comb begin
		pos_d     = pos_q;
		pending_d = pending_q;
		store_d   = store_q;
		emit      = 1'b0;
		clr       = 1'b0;
		if (q_pop) begin
			unique case (q_head.op)
				OP_RELEASE: begin
					if (pending_q) begin
						clr = 1'b1;
					end
				end
				OP_BYTE: begin
					if (!pending_q) begin
						if ((pos_q == pos_t'(0) && q_head.data != sync.byte0) ||
						    (pos_q == pos_t'(1) && q_head.data != sync.byte1)) begin
							clr = 1'b1;
						end else begin
							for (int i = 0; i < STORE_BYTES; i++) begin
								if (pos_q == pos_t'(FIRST_STORED + i)) begin
									store_d[i] = q_head.data;
								end
							end
							pos_d = pos_q + 1'b1;
							if (pos_cmp_t'(pos_d) >=
							    pos_cmp_t'(store_d[0]) + pos_cmp_t'(LEN_BIAS)) begin
								pending_d = 1'b1;
								emit      = 1'b1;
							end
						end
					end
				end
			endcase
		end
		if (clr) begin
			pos_d     = '0;
			pending_d = 1'b0;
			for (int i = 0; i < STORE_BYTES; i++) begin
				store_d[i] = '0;
			end
		end
	end

	// Unpack the frame bytes into result fields.
	always_comb begin
		res_d.frame_length    = store_d[0];
		res_d.command_type    = store_d[1];
		res_d.node_id         = {store_d[4], store_d[3], store_d[2]};
		res_d.payload_present = (store_d[0] == PAYLOAD_LEN);
		res_d.payload         = res_d.payload_present ? {store_d[6], store_d[5]} : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < STORE_BYTES; i++) begin
				store_q[i] <= '0;
			end
		end else begin
			pos_q     <= pos_d;
			pending_q <= pending_d;
			store_q   <= store_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_result_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> pending_q)
		else $error("result waiting without a pending frame");

	a_pending_length: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (pos_cmp_t'(pos_q) ==
		               pos_cmp_t'(store_q[0]) + pos_cmp_t'(LEN_BIAS)))
		else $error("pending frame position does not match its length");

	a_header_store_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q < pos_t'(FIRST_STORED)) |-> (store_q[0] == 8'd0 && store_q[1] == 8'd0))
		else $error("store not clear during header hunt");

	a_pending_emits: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pending_q) |-> out_valid_q)
		else $error("frame completed without a result");
`endif

endmodule

[src/header_length_frame_receiver.sv]
// Top level of the header/length frame receiver: configuration, front and back end.
//
// Receives one word per cycle. A word with req_type 0 carries a received byte;
// with req_type 1 it asks to release a pending frame. The receiver hunts for
// the two header bytes (sync_first, sync_second; reset 0xAA, 0x55), takes the
// next byte as length L and completes the frame after L+3 bytes in all, then
// presents one result: length, command type, 24-bit node id (byte 4 low)
// and, when L is 6, the 16-bit payload (byte 7 low) with payload_present set.
// A header byte that does not match restarts the hunt without retrying that
// byte. Bytes arriving while a frame is pending are dropped; a release clears
// the frame and rearms the hunt, and a release with nothing pending is ignored.
// Bytes beyond the ninth are not kept but still count toward L+3.
// Throughput is one word per cycle unless a result waits untaken on the output:
// the frame state updates once per word. Words enter a four-entry queue at the
// input and the back end takes one word per cycle from it while no result is
// held; a result is registered on the output when the back end takes the word
// that completes the frame, and stays there until taken while the queue keeps
// accepting input until it is full. Configuration writes are always
// accepted (cfg_ready is tied high); indexes beyond sync_second are dropped.
// Write configuration only while no words are in flight.
module header_length_frame_receiver (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hlfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     frame_length,
	output logic [7:0]                     command_type,
	output logic [23:0]                    node_id,
	output logic [15:0]                    payload,
	output logic                           payload_present
);
	import hlfr_pkg::*;

	sync_t      sync_q;
	logic       q_valid;
	logic       q_pop;
	q_entry_t   q_head;
	frame_res_t res;

	// Header registers; take every write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q.byte0 <= SYNC_FIRST_RST;
			sync_q.byte1 <= SYNC_SECOND_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SYNC_FIRST:  sync_q.byte0 <= cfg_data;
				CFG_SYNC_SECOND: sync_q.byte1 <= cfg_data;
				default: ;  // drop writes to unknown indexes
			endcase
		end
	end

	// Front: classify and queue incoming words.
	hlfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.rx_byte  (rx_byte),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_head   (q_head)
	);

	// Back: advance the frame state and hold the result until taken.
	hlfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.sync      (sync_q),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign frame_length    = res.frame_length;
	assign command_type    = res.command_type;
	assign node_id         = res.node_id;
	assign payload         = res.payload;
	assign payload_present = res.payload_present;

endmodule

[tb/sv/header_length_frame_receiver_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the header/length frame receiver.
module header_length_frame_receiver_test;
	import hlfr_pkg::*;

	// Depth of the shadow receive store; bytes at or past it only count.
	localparam int STORE_DEPTH = 16;
	// Register index with no register behind it: writes to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	// Cycles to let trailing words drain through the input queue and back end.
	localparam int SETTLE_CYCLES = 10;
	// Cycles with no word moving on any channel before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_PRINTED = 40;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 req_type = 1'b0;
	logic [7:0]           rx_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [7:0]           frame_length;
	logic [7:0]           command_type;
	logic [23:0]          node_id;
	logic [15:0]          payload;
	logic                 payload_present;

	// Shadow copy of the receiver: header registers, position, store, pending flag.
	logic [7:0] sync_first_q = SYNC_FIRST_RST;
	logic [7:0] sync_second_q = SYNC_SECOND_RST;
	logic [8:0] rx_pos;
	logic [7:0] rx_store [STORE_DEPTH];
	logic       frame_held;

	// Parsed frames still owed by the block, oldest first.
	frame_res_t frames_due [$];

	int  words_sent = 0;
	int  errors = 0;
	int  stall_count = 0;
	// Set to hold both sides busy every cycle.
	bit  calm = 1'b0;

	header_length_frame_receiver i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.frame_length    (frame_length),
		.command_type    (command_type),
		.node_id         (node_id),
		.payload         (payload),
		.payload_present (payload_present)
	);

	always #4 clk = ~clk;

	// Drop the frame in progress and rearm the header hunt.
	function automatic void clear_rx();
		foreach (rx_store[i]) rx_store[i] = 8'h00;
		rx_pos = '0;
		frame_held = 1'b0;
	endfunction

	// Advance the shadow receiver by one accepted word; queue a frame if it completes.
	function automatic void decode_word(op_t op, logic [7:0] data);
		logic [8:0] pos;
		frame_res_t res;
		if (op == OP_RELEASE) begin
			// a release with nothing pending leaves the partial frame alone
			if (frame_held)
				clear_rx();
			return;
		end
		// bytes arriving while a frame waits for release are dropped
		if (frame_held)
			return;
		pos = rx_pos;
		if (pos < STORE_DEPTH)
			rx_store[pos[3:0]] = data;
		// a bad header byte restarts the hunt and is not retried as a first byte
		if ((pos == 9'd0 && data != sync_first_q) || (pos == 9'd1 && data != sync_second_q)) begin
			clear_rx();
			return;
		end
		pos = pos + 9'd1;
		rx_pos = pos;
		// before the length byte lands, store slot 2 is still zero
		if (int'(pos) >= int'(rx_store[2]) + LEN_BIAS) begin
			frame_held = 1'b1;
			res.frame_length = rx_store[2];
			res.command_type = rx_store[3];
			res.node_id = {rx_store[6], rx_store[5], rx_store[4]};
			res.payload_present = (rx_store[2] == PAYLOAD_LEN);
			res.payload = res.payload_present ? {rx_store[8], rx_store[7]} : 16'h0000;
			frames_due.push_back(res);
		end
	endfunction

	// Frame lengths: mostly the payload-carrying one, some short, some past the store.
	function automatic logic [7:0] pick_length();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return PAYLOAD_LEN;
		if (roll < 85)
			return 8'($urandom_range(0, 8));
		return 8'($urandom_range(9, 20));
	endfunction

	task automatic report_mismatch(input string what);
		if (errors < MAX_PRINTED)
			$display("mismatch at %0t ns: %s", $time, what);
		errors++;
	endtask

	// Offer one word and hold it until taken; idle beforehand now and then.
	task automatic send_word(input op_t op, input logic [7:0] data);
		int gap;
		if (!calm && $urandom_range(99) < 4) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		rx_byte <= data;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		decode_word(op, data);
		words_sent++;
	endtask

	task automatic send_header(input logic [7:0] len);
		send_word(OP_BYTE, sync_first_q);
		send_word(OP_BYTE, sync_second_q);
		send_word(OP_BYTE, len);
	endtask

	task automatic send_frame(input logic [7:0] len);
		send_header(len);
		repeat (len)
			send_word(OP_BYTE, 8'($urandom));
	endtask

	// Stop sending, wait for every owed frame, then let stray words drain.
	task automatic settle();
		in_valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Load both header registers, then poke the unused index, all while idle.
	task automatic write_sync(input logic [7:0] first, input logic [7:0] second);
		logic [CFG_IDX_W-1:0] idx;
		logic [7:0] val;
		settle();
		for (int k = 0; k < 3; k++) begin
			idx = (k == 0) ? CFG_SYNC_FIRST : (k == 1) ? CFG_SYNC_SECOND : CFG_SPARE;
			val = (k == 0) ? first : (k == 1) ? second : 8'($urandom);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			if (idx == CFG_SYNC_FIRST)
				sync_first_q = val;
			else if (idx == CFG_SYNC_SECOND)
				sync_second_q = val;
		end
		cfg_valid <= 1'b0;
	endtask

	// Hand-picked words on the reset header values.
	task automatic test_directed_frames();
		// full payload frame with every body bit set
		send_header(PAYLOAD_LEN);
		repeat (6)
			send_word(OP_BYTE, 8'hFF);
		// byte while pending: dropped
		send_word(OP_BYTE, 8'h00);
		send_word(OP_RELEASE, 8'hFF);
		// second header byte wrong, then the next byte fails as a first byte
		send_word(OP_BYTE, sync_first_q);
		send_word(OP_BYTE, sync_first_q);
		send_word(OP_BYTE, sync_second_q);
		// zero length completes on the length byte itself
		send_header(8'h00);
		send_word(OP_RELEASE, 8'h00);
		// short frame, with a release in the middle that must be ignored
		send_header(8'd2);
		send_word(OP_RELEASE, 8'h00);
		send_word(OP_BYTE, 8'h00);
		send_word(OP_BYTE, 8'h80);
		send_word(OP_RELEASE, 8'h00);
	endtask

	// Frames that end at the store edge, cross it, and the longest one.
	task automatic test_long_frames();
		send_frame(8'(STORE_DEPTH - LEN_BIAS));
		send_word(OP_RELEASE, 8'($urandom));
		send_frame(8'(STORE_DEPTH - LEN_BIAS + 1));
		send_word(OP_RELEASE, 8'($urandom));
		send_frame(8'hFF);
		send_word(OP_RELEASE, 8'($urandom));
	endtask

	// Both sides busy every cycle: no gaps, no back-pressure.
	task automatic test_back_to_back();
		calm = 1'b1;
		repeat (12) begin
			send_frame(pick_length());
			send_word(OP_RELEASE, 8'($urandom));
		end
		settle();
		calm = 1'b0;
	endtask

	// Header registers at their extremes, with the old header now rejected.
	task automatic test_sync_registers();
		write_sync(8'h00, 8'hFF);
		send_frame(PAYLOAD_LEN);
		send_word(OP_RELEASE, 8'h00);
		send_word(OP_BYTE, SYNC_FIRST_RST);
		send_frame(8'd3);
		send_word(OP_RELEASE, 8'h00);
		write_sync(8'hFF, 8'h00);
		send_frame(PAYLOAD_LEN);
		send_word(OP_RELEASE, 8'h00);
		send_word(OP_BYTE, 8'h00);
		send_frame(8'd5);
		send_word(OP_RELEASE, 8'h00);
	endtask

	// Random traffic under one header setting: mostly clean frames, some breakage.
	task automatic test_random_traffic(input logic [7:0] first, input logic [7:0] second,
			input int words);
		int stop_at;
		int pause_at;
		int roll;
		int cut;
		logic [7:0] len;
		write_sync(first, second);
		stop_at = words_sent + words;
		pause_at = words_sent + $urandom_range(words / 4, 3 * words / 4);
		while (words_sent < stop_at) begin
			roll = $urandom_range(99);
			if (frame_held)
				send_word(OP_RELEASE, 8'($urandom));
			if (roll < 70) begin
				send_frame(pick_length());
				// trailing bytes while the frame is pending
				repeat ($urandom_range(0, 2))
					send_word(OP_BYTE, 8'($urandom));
			end else if (roll < 78) begin
				// break the header in its first or its second byte
				if ($urandom_range(1)) begin
					send_word(OP_BYTE, sync_first_q ^ 8'($urandom_range(1, 255)));
				end else begin
					send_word(OP_BYTE, sync_first_q);
					send_word(OP_BYTE, sync_second_q ^ 8'($urandom_range(1, 255)));
				end
			end else if (roll < 86) begin
				// release lands mid-frame and the frame carries on
				len = pick_length();
				cut = $urandom_range(0, len);
				send_header(len);
				repeat (cut)
					send_word(OP_BYTE, 8'($urandom));
				send_word(OP_RELEASE, 8'($urandom));
				repeat (len - cut)
					send_word(OP_BYTE, 8'($urandom));
			end else if (roll < 93) begin
				send_word(OP_RELEASE, 8'($urandom));
			end else begin
				repeat ($urandom_range(1, 4))
					send_word(OP_BYTE, 8'($urandom));
			end
			// hold off once per phase until the block has caught up
			if (pause_at > 0 && words_sent >= pause_at) begin
				settle();
				pause_at = 0;
			end
		end
	endtask

	// Back-pressure on the result side, dropped while the stretch without idling runs.
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 10);
	end

	// Compare each taken frame field by field against the oldest owed one.
	always @(posedge clk) begin : check_results
		frame_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frames_due.size() == 0) begin
				report_mismatch("frame delivered with none owed");
			end else begin
				want = frames_due.pop_front();
				if (frame_length !== want.frame_length)
					report_mismatch($sformatf("frame_length %h, want %h",
						frame_length, want.frame_length));
				if (command_type !== want.command_type)
					report_mismatch($sformatf("command_type %h, want %h",
						command_type, want.command_type));
				if (node_id !== want.node_id)
					report_mismatch($sformatf("node_id %h, want %h",
						node_id, want.node_id));
				if (payload !== want.payload)
					report_mismatch($sformatf("payload %h, want %h",
						payload, want.payload));
				if (payload_present !== want.payload_present)
					report_mismatch($sformatf("payload_present %b, want %b",
						payload_present, want.payload_present));
			end
		end
	end

	// Watchdog: count cycles in which no word moves on any channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stall_count <= 0;
		end else if (arst_n) begin
			stall_count <= stall_count + 1;
			if (stall_count >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		clear_rx();
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);
		test_directed_frames();
		test_long_frames();
		test_back_to_back();
		test_sync_registers();
		test_random_traffic(SYNC_FIRST_RST, SYNC_SECOND_RST, 70);
		test_random_traffic(8'h00, 8'hFF, 50);
		test_random_traffic(8'hFF, 8'h00, 50);
		// equal header bytes: a repeated first byte must not be retried
		test_random_traffic(8'h5A, 8'h5A, 40);
		test_random_traffic(8'($urandom), 8'($urandom), 40);
		settle();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[header_length_frame_receiver.f]
src/hlfr_pkg.sv
src/hlfr_front.sv
src/hlfr_back.sv
src/header_length_frame_receiver.sv
tb/sv/header_length_frame_receiver_test.sv
